[sv/pip_pkg.sv]
package pip_pkg;
	localparam int CoordWidth = 32;

	// one edge job handed from the front end to the crossing unit
	typedef struct packed {
		logic [63:0] ix;
		logic [63:0] iy;
		logic [63:0] jx;
		logic [63:0] jy;
		logic [63:0] tx;
		logic [63:0] ty;
		logic        emit;
	} edge_job_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} xu_state_t;
endpackage

[sv/pip_front.sv]
module pip_front #(
	parameter int CW = pip_pkg::CoordWidth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [CW-1:0]      vertex_x,
	input  logic [CW-1:0]      vertex_y,
	input  logic [CW-1:0]      test_x,
	input  logic [CW-1:0]      test_y,
	input  logic               last_vertex,
	output logic               job_valid,
	output pip_pkg::edge_job_t job,
	input  logic               job_take
);
	import pip_pkg::*;

	logic [63:0] vx, vy, tx, ty, first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic        expect_first_q, close_pend_q;
	edge_job_t   job_q;
	logic        job_valid_q;
	logic        slot_free, acc, job_load;

	assign vx = {{(64-CW){vertex_x[CW-1]}}, vertex_x};
	assign vy = {{(64-CW){vertex_y[CW-1]}}, vertex_y};
	assign tx = {{(64-CW){test_x[CW-1]}}, test_x};
	assign ty = {{(64-CW){test_y[CW-1]}}, test_y};

	assign slot_free = !job_valid_q || job_take;
	assign in_stall  = close_pend_q || !slot_free;
	assign acc       = in_valid && !in_stall;
	assign job_load  = (close_pend_q && slot_free) || acc;
	assign job_valid = job_valid_q;
	assign job       = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_first_q <= 1'b1;
			close_pend_q   <= 1'b0;
			job_valid_q    <= 1'b0;
		end else begin
			job_valid_q <= job_load || (job_valid_q && !job_take);
			if (close_pend_q && slot_free) begin
				// closing edge: last vertex back to first
				job_q        <= '{ix: prev_x_q, iy: prev_y_q, jx: first_x_q, jy: first_y_q,
					tx: job_q.tx, ty: job_q.ty, emit: 1'b1};
				close_pend_q <= 1'b0;
			end else if (acc) begin
				prev_x_q <= vx;
				prev_y_q <= vy;
				if (expect_first_q) begin
					first_x_q <= vx;
					first_y_q <= vy;
				end
				// first vertex: degenerate self edge never crosses, keeps tx/ty
				job_q <= '{ix: expect_first_q ? vx : prev_x_q,
					iy: expect_first_q ? vy : prev_y_q, jx: vx, jy: vy,
					tx: tx, ty: ty, emit: 1'b0};
				close_pend_q   <= last_vertex;
				expect_first_q <= last_vertex;
			end
		end
	end
endmodule

[sv/pip_xunit.sv]
module pip_xunit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	input  pip_pkg::edge_job_t job,
	output logic               job_take,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               is_inside
);
	import pip_pkg::*;

	xu_state_t   st_q, st_d;
	logic [63:0] ix_q, tx_q, dxm_q, tm_q, dm_q, quo_q, rem_q;
	logic [127:0] num_q, pp_sh;
	logic        neg_q, emit_q, strad_q, parity_q, out_valid_q, out_valid_d, is_inside_q;
	logic [6:0]  cnt_q;
	logic [1:0]  mcnt_q;
	logic        straddle, hold, hit;
	logic [31:0] dxm_half, tm_half;
	logic [63:0] pp;
	logic [64:0] rsh;
	logic        ge;
	logic [63:0] base;
	logic signed [63:0] cut;

	function automatic logic [63:0] absd(input logic [63:0] a, input logic [63:0] b);
		return ($signed(a) >= $signed(b)) ? a - b : b - a;
	endfunction

	assign straddle = ($signed(job.iy) > $signed(job.ty)) != ($signed(job.jy) > $signed(job.ty));
	assign hold     = out_valid_q && !out_stall;
	assign rsh      = {rem_q, num_q[127]};
	assign ge       = rsh >= {1'b0, dm_q};
	assign base     = neg_q ? ix_q - quo_q : ix_q + quo_q;
	assign hit      = strad_q && ($signed(tx_q) < cut);

	// one 32x32 partial product per multiply cycle
	assign dxm_half = mcnt_q[1] ? dxm_q[63:32] : dxm_q[31:0];
	assign tm_half  = mcnt_q[0] ? tm_q[63:32] : tm_q[31:0];
	assign pp       = 64'(dxm_half) * 64'(tm_half);

	always_comb begin
		unique case (mcnt_q)
			2'd0:       pp_sh = {64'd0, pp};
			2'd1, 2'd2: pp_sh = {32'd0, pp, 32'd0};
			2'd3:       pp_sh = {pp, 64'd0};
			default:    pp_sh = {64'd0, pp};
		endcase
	end

	always_comb begin
		cut = $signed(base);
		if (rem_q != 64'd0) begin
			if (!neg_q && $signed(base) < 0)      cut = $signed(base) + 64'sd1;
			else if (neg_q && $signed(base) > 0)  cut = $signed(base) - 64'sd1;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (job_valid) st_d = straddle ? ST_MUL : ST_DONE;
			ST_MUL:  if (mcnt_q == 2'd3) st_d = ST_DIV;
			ST_DIV:  if (cnt_q == 7'd127) st_d = ST_DONE;
			ST_DONE: if (!emit_q || !out_valid_q || !out_stall) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		job_take    = (st_q == ST_IDLE) && job_valid;
		out_valid_d = out_valid_q && !hold;
		if (st_q == ST_DONE && st_d == ST_IDLE && emit_q)
			out_valid_d = 1'b1;
	end

	assign out_valid = out_valid_q;
	assign is_inside = is_inside_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			parity_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q        <= st_d;
			out_valid_q <= out_valid_d;
			unique case (st_q)
				ST_IDLE: if (job_valid) begin
					ix_q    <= job.ix;
					tx_q    <= job.tx;
					neg_q   <= $signed(job.jx) < $signed(job.ix);
					dxm_q   <= absd(job.jx, job.ix);
					tm_q    <= absd(job.ty, job.iy);
					dm_q    <= absd(job.jy, job.iy);
					emit_q  <= job.emit;
					strad_q <= straddle;
					quo_q   <= 64'd0;
					rem_q   <= 64'd0;
					num_q   <= 128'd0;
					cnt_q   <= 7'd0;
					mcnt_q  <= 2'd0;
				end
				ST_MUL: begin
					num_q  <= num_q + pp_sh;
					mcnt_q <= mcnt_q + 2'd1;
				end
				ST_DIV: begin
					num_q <= num_q << 1;
					if (ge) begin
						rem_q <= 64'(rsh - {1'b0, dm_q});
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= rsh[63:0];
						quo_q <= {quo_q[62:0], 1'b0};
					end
					cnt_q <= cnt_q + 7'd1;
				end
				ST_DONE: if (st_d == ST_IDLE) begin
					if (emit_q) begin
						is_inside_q <= parity_q ^ hit;
						parity_q    <= 1'b0;
					end else begin
						parity_q <= parity_q ^ hit;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

[sv/point_in_polygon_ray_cast.sv]
// Point-in-polygon crossing test. Vertices stream in one per transaction with the
// test point; last_vertex closes the polygon and one is_inside transaction follows.
// Each straddling edge passes through the crossing unit in order: taking the
// job, four 32x32 partial products, a 128-step restoring divider at one
// quotient bit per cycle, and a parity update; an edge that does not
// straddle skips the products and the divider. The last vertex yields both its own
// edge and the closing one. The front end holds first/previous vertex and a
// one-entry job slot, so it accepts the next vertex while an edge divides.
// The closing edge is queued behind the last vertex's edge once the job slot frees.
module point_in_polygon_ray_cast #(
	parameter int COORD_WIDTH = pip_pkg::CoordWidth
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [COORD_WIDTH-1:0] vertex_x,
	input  logic [COORD_WIDTH-1:0] vertex_y,
	input  logic [COORD_WIDTH-1:0] test_x,
	input  logic [COORD_WIDTH-1:0] test_y,
	input  logic                   last_vertex,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   is_inside
);
	import pip_pkg::*;

	edge_job_t job;
	logic      job_valid, job_take;

	pip_front #(.CW(COORD_WIDTH)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .vertex_x, .vertex_y, .test_x, .test_y,
		.last_vertex, .job_valid, .job, .job_take
	);

	pip_xunit u_xunit (
		.clk, .arst_n, .job_valid, .job, .job_take, .out_valid, .out_stall, .is_inside
	);
endmodule

[sv/pip_checker.sv]
module pip_props (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic last_vertex,
	input logic out_valid,
	input logic out_stall,
	input logic is_inside
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(is_inside)) else $error("out held");
	a_last_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_vertex |=> in_stall) else $error("close edge");
	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown(is_inside))
		else $error("unknown result");
endmodule

bind point_in_polygon_ray_cast pip_props u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .last_vertex, .out_valid, .out_stall, .is_inside
);

[bench/pip_checker.sv]
`timescale 1ns / 100ps

module pip_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [31:0] vertex_x,
	input  logic [31:0] vertex_y,
	input  logic [31:0] test_x,
	input  logic [31:0] test_y,
	input  logic        last_vertex,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        is_inside,
	output int          errors,
	output int          pending
);
	longint first_x, first_y, prev_x, prev_y;
	bit     parity, want_first;
	bit     inside_q[$];

	// exact edge x at the test y, truncated toward zero, vs. test x
	function automatic bit ray_hits(longint px, longint py, longint ix, longint iy,
			longint jx, longint jy);
		longint unsigned dxm, tm, dm;
		logic [127:0]    prod, q, r;
		bit              neg;
		longint          cut;
		if ((iy > py) == (jy > py))
			return 0;
		neg  = jx < ix;
		dxm  = neg ? ix - jx : jx - ix;
		tm   = (py >= iy) ? py - iy : iy - py;
		dm   = (jy >= iy) ? jy - iy : iy - jy;
		prod = {64'd0, dxm} * {64'd0, tm};
		q    = prod / {64'd0, dm};
		r    = prod % {64'd0, dm};
		cut  = neg ? ix - longint'(q[63:0]) : ix + longint'(q[63:0]);
		if (r != 0) begin
			if (!neg && cut < 0)
				cut = cut + 1;
			else if (neg && cut > 0)
				cut = cut - 1;
		end
		return px < cut;
	endfunction

	assign pending = inside_q.size();

	always @(posedge clk or negedge arst_n) begin
		longint vx, vy, tx, ty;
		bit     got;
		if (!arst_n) begin
			first_x    = 0;
			first_y    = 0;
			prev_x     = 0;
			prev_y     = 0;
			parity     = 0;
			want_first = 1;
			errors     = 0;
			inside_q.delete();
		end else begin
			if (in_valid && !in_stall) begin
				vx = longint'($signed(vertex_x));
				vy = longint'($signed(vertex_y));
				tx = longint'($signed(test_x));
				ty = longint'($signed(test_y));
				if (want_first) begin
					first_x    = vx;
					first_y    = vy;
					parity     = 0;
					want_first = 0;
				end else if (ray_hits(tx, ty, prev_x, prev_y, vx, vy)) begin
					parity = !parity;
				end
				prev_x = vx;
				prev_y = vy;
				if (last_vertex) begin
					// closing edge back to the first vertex
					if (ray_hits(tx, ty, prev_x, prev_y, first_x, first_y))
						parity = !parity;
					inside_q.push_back(parity);
					parity     = 0;
					want_first = 1;
				end
			end
			if (out_valid && !out_stall) begin
				if (inside_q.size() == 0) begin
					$error("is_inside: unexpected transaction, actual %0d", is_inside);
					errors++;
				end else begin
					got = inside_q.pop_front();
					if (is_inside !== got) begin
						$error("is_inside: expected %0d actual %0d", got, is_inside);
						errors++;
					end
				end
			end
		end
	end
endmodule

[bench/point_in_polygon_ray_cast_tb.sv]
`timescale 1ns / 100ps

module point_in_polygon_ray_cast_tb;
	localparam int RandomItems = 1450;
	localparam int StallLimit  = 20000; // idle cycles before the watchdog trips
	localparam int HoldCycles  = 3000;  // long receiver hold-off
	localparam int DrainCycles = 400;   // two straddling edges plus margin
	localparam logic [31:0] MaxC = 32'h7fff_ffff;
	localparam logic [31:0] MinC = 32'h8000_0000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] vertex_x;
	logic [31:0] vertex_y;
	logic [31:0] test_x;
	logic [31:0] test_y;
	logic        last_vertex;
	logic        out_valid;
	logic        out_stall;
	logic        is_inside;

	int errors;
	int pending;
	int idle_cycles;
	bit calm;      // no idling on either side while set
	bit hold_req;  // asks the receiver for a long hold-off
	bit hold_done; // the hold-off was requested once
	int sent;

	point_in_polygon_ray_cast u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.vertex_x    (vertex_x),
		.vertex_y    (vertex_y),
		.test_x      (test_x),
		.test_y      (test_y),
		.last_vertex (last_vertex),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.is_inside   (is_inside)
	);

	pip_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.vertex_x    (vertex_x),
		.vertex_y    (vertex_y),
		.test_x      (test_x),
		.test_y      (test_y),
		.last_vertex (last_vertex),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.is_inside   (is_inside),
		.errors      (errors),
		.pending     (pending)
	);

	initial clk = 0;
	always #10 clk = ~clk;

	// watchdog: counts cycles where neither channel moves a transaction
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver: random stall, or one long hold-off on request
	initial begin
		out_stall = 1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1;
				repeat (HoldCycles) @(negedge clk);
				hold_req = 0;
			end
			out_stall <= !calm && ($urandom_range(0, 99) < 37);
		end
	end

	// one vertex transaction; valid stays high into the next call
	task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] tx, input logic [31:0] ty, input logic last);
		while (!calm && $urandom_range(0, 99) < 37) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid    <= 1;
		vertex_x    <= x;
		vertex_y    <= y;
		test_x      <= tx;
		test_y      <= ty;
		last_vertex <= last;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		sent++;
	endtask

	function automatic logic [31:0] pick_coord(bit wide);
		if (wide)
			return $urandom;
		return 32'($signed($urandom_range(0, 200)) - 100);
	endfunction

	// random polygon with a random test point; some have a wandering test point
	task automatic send_polygon();
		int          n;
		bit          wide, wander;
		logic [31:0] tx, ty;
		n      = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
		wide   = $urandom_range(0, 3) == 0;
		wander = $urandom_range(0, 9) == 0;
		tx     = pick_coord(wide);
		ty     = pick_coord(wide);
		for (int i = 0; i < n; i++) begin
			if (wander) begin
				tx = pick_coord(wide);
				ty = pick_coord(wide);
			end
			// vertices sometimes sit exactly on the test y
			send_vertex(pick_coord(wide),
				($urandom_range(0, 7) == 0) ? ty : pick_coord(wide), tx, ty, i == n - 1);
		end
	endtask

	initial begin
		in_valid    = 0;
		vertex_x    = 0;
		vertex_y    = 0;
		test_x      = 0;
		test_y      = 0;
		last_vertex = 0;
		calm        = 0;
		hold_req    = 0;
		hold_done   = 0;
		sent        = 0;
		idle_cycles = 0;
		arst_n      = 0;
		repeat (10) @(posedge clk);
		arst_n = 1;
		@(negedge clk);

		// single vertex polygon: closing edge to itself never counts
		send_vertex(5, 5, 0, 5, 1);
		// square around the origin: inside
		send_vertex(-10, -10, 0, 0, 0);
		send_vertex(10, -10, 0, 0, 0);
		send_vertex(10, 10, 0, 0, 0);
		send_vertex(-10, 10, 0, 0, 1);
		// same square, point outside to the right
		send_vertex(-10, -10, 20, 0, 0);
		send_vertex(10, -10, 20, 0, 0);
		send_vertex(10, 10, 20, 0, 0);
		send_vertex(-10, 10, 20, 0, 1);
		// horizontal edges at test y: never counted
		send_vertex(-5, 0, -9, 0, 0);
		send_vertex(5, 0, -9, 0, 0);
		send_vertex(0, 7, -9, 0, 1);
		// full-range triangle, extreme coordinates and test point
		send_vertex(MinC, MinC, 0, 0, 0);
		send_vertex(MaxC, MinC, 0, 0, 0);
		send_vertex(0, MaxC, 0, 0, 1);
		send_vertex(MinC, MinC, MinC, MaxC - 1, 0);
		send_vertex(MaxC, MaxC, MinC, MaxC - 1, 0);
		send_vertex(MinC, MaxC, MinC, MaxC - 1, 1);
		// sloped edges with inexact cut, negative and positive side
		send_vertex(-3, -7, -2, 1, 0);
		send_vertex(4, 9, -2, 1, 0);
		send_vertex(-8, 9, -2, 1, 1);
		send_vertex(MaxC, -1, -1, 0, 0);
		send_vertex(MinC, 1, -1, 0, 1);

		sent = 0;
		while (sent < RandomItems) begin
			calm = (sent >= 400 && sent < 600);
			if (sent >= 900 && !hold_done) begin
				hold_req  = 1;
				hold_done = 1;
			end
			send_polygon();
		end
		in_valid <= 0;
		calm = 0;

		while (pending != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

[files.f]
sv/pip_pkg.sv
sv/pip_front.sv
sv/pip_xunit.sv
sv/point_in_polygon_ray_cast.sv
sv/pip_checker.sv
bench/pip_checker.sv
bench/point_in_polygon_ray_cast_tb.sv
